// ----- sv/visibility_ratio_threshold_tracker_core_assert.svh -----
// assertion macros for the visibility ratio tracker checker
// depends on nothing; included by the checker file
`ifndef VISIBILITY_RATIO_THRESHOLD_TRACKER_CORE_ASSERT_SVH
`define VISIBILITY_RATIO_THRESHOLD_TRACKER_CORE_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define VRTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also runs during reset
`define VRTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/vrtt_pkg.sv -----
// shared types and constants for the visibility ratio tracker
// no dependencies
`default_nettype none

package vrtt_pkg;

    // field widths
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int EXT_BITS   = COORD_BITS + 3;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int REM_BITS   = AREA_BITS + 1;
    localparam int RATIO_BITS = 16;
    localparam int SLOT_BITS  = 6;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;

    // parameter defaults
    localparam int TARGET_SLOTS_DEF   = 64;
    localparam int MAX_THRESHOLDS_DEF = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROOT_X          = 3'd0,
        CFG_ROOT_Y          = 3'd1,
        CFG_ROOT_WIDTH      = 3'd2,
        CFG_ROOT_HEIGHT     = 3'd3,
        CFG_MARGINS         = 3'd4,
        CFG_ROOT_IS_ELEMENT = 3'd5,
        CFG_THRESHOLDS      = 3'd6,
        CFG_THRESHOLD_COUNT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SLOT_BITS-1:0]         slot;
        logic                         restart;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic [SIZE_BITS-1:0]         target_width;
        logic [SIZE_BITS-1:0]         target_height;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_BITS-1:0]         out_slot;
        logic                         visible;
        logic [RATIO_BITS-1:0]        visible_ratio;
        logic signed [COORD_BITS-1:0] clip_x;
        logic signed [COORD_BITS-1:0] clip_y;
        logic [SIZE_BITS-1:0]         clip_width;
        logic [SIZE_BITS-1:0]         clip_height;
        logic signed [COORD_BITS-1:0] box_x;
        logic signed [COORD_BITS-1:0] box_y;
        logic [SIZE_BITS-1:0]         box_width;
        logic [SIZE_BITS-1:0]         box_height;
    } t_out_beat;

    // per-stage pipeline contents
    typedef struct packed {
        logic [SLOT_BITS-1:0]         slot;
        logic                         restart;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        logic [SIZE_BITS-1:0]         tw;
        logic [SIZE_BITS-1:0]         th;
        logic signed [EXT_BITS-1:0]   rl;
        logic signed [EXT_BITS-1:0]   rt;
        logic signed [EXT_BITS-1:0]   rr;
        logic signed [EXT_BITS-1:0]   rb;
        logic signed [EXT_BITS-1:0]   tr;
        logic signed [EXT_BITS-1:0]   tb;
        logic                         vis;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [SIZE_BITS-1:0]         cw;
        logic [SIZE_BITS-1:0]         ch;
        logic [AREA_BITS-1:0]         carea;
        logic [AREA_BITS-1:0]         tarea;
        logic [REM_BITS-1:0]          rem;
        logic [RATIO_BITS-1:0]        q;
    } t_pipe;

    // slot history entry
    typedef struct packed {
        logic                  seen;
        logic [RATIO_BITS-1:0] ratio;
    } t_hist;

endpackage

`default_nettype wire

// ----- sv/visibility_ratio_threshold_tracker_core.sv -----
// Visibility ratio tracker: clips one target box per beat against the root box, forms
// the visible area ratio in Q1.15 and reports a slot on first sighting, on restart or on a threshold
// crossing. Fully pipelined: one beat per cycle while the output is not stalled, 20 pipeline
// stages plus an output register. The 16 quotient bits of the ratio come from one restoring
// divide step per stage. After reset the slot history memory is swept clear, one entry a
// cycle; no input beat is taken during the sweep. A stalled output stalls the whole pipeline.
// depends on vrtt_pkg
`default_nettype none

module visibility_ratio_threshold_tracker_core #(
    parameter int TARGET_SLOTS   = vrtt_pkg::TARGET_SLOTS_DEF,
    parameter int MAX_THRESHOLDS = vrtt_pkg::MAX_THRESHOLDS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire vrtt_pkg::t_in_beat                 i_in_beat,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output vrtt_pkg::t_out_beat                     o_out_beat,
    input  wire logic                               i_cfg_we,
    input  wire logic [vrtt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [vrtt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SLOT_AW  = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int SLOT_VALS = 1 << vrtt_pkg::SLOT_BITS;
    localparam int NST      = 20;
    localparam int DIV_FIRST = 3;
    localparam int LAST     = NST - 1;
    localparam int CW       = vrtt_pkg::EXT_BITS;
    localparam int SW       = vrtt_pkg::SIZE_BITS;
    localparam int XW       = vrtt_pkg::COORD_BITS;
    localparam int RB       = vrtt_pkg::RATIO_BITS;

    // configuration registers
    logic signed [XW-1:0] r_root_x, r_root_y;
    logic [SW-1:0]        r_root_w, r_root_h;
    logic [63:0]          r_margins, r_thresholds;
    logic                 r_root_elem;
    logic [2:0]           r_thr_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x     <= '0;
            r_root_y     <= '0;
            r_root_w     <= '0;
            r_root_h     <= '0;
            r_margins    <= '0;
            r_root_elem  <= 1'b0;
            r_thresholds <= '0;
            r_thr_count  <= 3'd1;
        end else if (i_cfg_we) begin
            case (vrtt_pkg::t_cfg_idx'(i_cfg_idx))
                vrtt_pkg::CFG_ROOT_X:          r_root_x     <= i_cfg_data[XW-1:0];
                vrtt_pkg::CFG_ROOT_Y:          r_root_y     <= i_cfg_data[XW-1:0];
                vrtt_pkg::CFG_ROOT_WIDTH:      r_root_w     <= i_cfg_data[SW-1:0];
                vrtt_pkg::CFG_ROOT_HEIGHT:     r_root_h     <= i_cfg_data[SW-1:0];
                vrtt_pkg::CFG_MARGINS:         r_margins    <= i_cfg_data;
                vrtt_pkg::CFG_ROOT_IS_ELEMENT: r_root_elem  <= i_cfg_data[0];
                vrtt_pkg::CFG_THRESHOLDS:      r_thresholds <= i_cfg_data;
                vrtt_pkg::CFG_THRESHOLD_COUNT: r_thr_count  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                r_out_valid;
    vrtt_pkg::t_out_beat r_out;
    logic                r_clearing;
    logic [SLOT_AW-1:0]  r_clr_cnt;
    logic                w_adv;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv && !r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    vrtt_pkg::t_pipe r_st [NST];
    vrtt_pkg::t_pipe n_st [NST];
    logic            r_vld [NST];

    // stage 0: root box and target far edges
    logic signed [CW-1:0] w_mt, w_mr, w_mb, w_ml, w_rx, w_ry, w_rw, w_rh;
    always_comb begin
        w_mt = CW'($signed(r_margins[15:0]));
        w_mr = CW'($signed(r_margins[31:16]));
        w_mb = CW'($signed(r_margins[47:32]));
        w_ml = CW'($signed(r_margins[63:48]));
        w_rx = CW'(r_root_x);
        w_ry = CW'(r_root_y);
        w_rw = $signed(CW'(r_root_w));
        w_rh = $signed(CW'(r_root_h));
        n_st[0]         = '0;
        n_st[0].slot    = i_in_beat.slot;
        n_st[0].restart = i_in_beat.restart;
        n_st[0].tx      = i_in_beat.target_x;
        n_st[0].ty      = i_in_beat.target_y;
        n_st[0].tw      = i_in_beat.target_width;
        n_st[0].th      = i_in_beat.target_height;
        n_st[0].tr      = CW'(i_in_beat.target_x) + $signed(CW'(i_in_beat.target_width));
        n_st[0].tb      = CW'(i_in_beat.target_y) + $signed(CW'(i_in_beat.target_height));
        if (r_root_elem) begin
            n_st[0].rl = w_rx;
            n_st[0].rt = w_ry;
            n_st[0].rr = w_rx + w_rw;
            n_st[0].rb = w_ry + w_rh;
        end else begin
            n_st[0].rl = w_rx - w_ml;
            n_st[0].rt = w_ry - w_mt;
            n_st[0].rr = w_rx + w_rw + w_mr;
            n_st[0].rb = w_ry + w_rh + w_mb;
        end
    end

    // stage 1: clip box
    logic signed [CW-1:0] w_cl, w_ct, w_cr, w_cb, w_cw, w_ch;
    logic                 w_vis;
    always_comb begin
        w_cl  = (r_st[0].rl > CW'(r_st[0].tx)) ? r_st[0].rl : CW'(r_st[0].tx);
        w_ct  = (r_st[0].rt > CW'(r_st[0].ty)) ? r_st[0].rt : CW'(r_st[0].ty);
        w_cr  = (r_st[0].rr < r_st[0].tr) ? r_st[0].rr : r_st[0].tr;
        w_cb  = (r_st[0].rb < r_st[0].tb) ? r_st[0].rb : r_st[0].tb;
        w_cw  = w_cr - w_cl;
        w_ch  = w_cb - w_ct;
        w_vis = (w_cw > 0) && (w_ch > 0);
        n_st[1]     = r_st[0];
        n_st[1].vis = w_vis;
        n_st[1].cx  = w_vis ? w_cl[XW-1:0] : '0;
        n_st[1].cy  = w_vis ? w_ct[XW-1:0] : '0;
        n_st[1].cw  = w_vis ? w_cw[SW-1:0] : '0;
        n_st[1].ch  = w_vis ? w_ch[SW-1:0] : '0;
    end

    // stage 2: clip and target areas
    always_comb begin
        n_st[2]       = r_st[1];
        n_st[2].carea = r_st[1].cw * r_st[1].ch;
        n_st[2].tarea = r_st[1].tw * r_st[1].th;
    end

    // stage 3: top quotient bit, the clip area never exceeds the target area
    always_comb begin
        n_st[DIV_FIRST] = r_st[DIV_FIRST-1];
        if ({1'b0, r_st[DIV_FIRST-1].carea} >= {1'b0, r_st[DIV_FIRST-1].tarea}) begin
            n_st[DIV_FIRST].q   = RB'(1) << (RB - 1);
            n_st[DIV_FIRST].rem = {1'b0, r_st[DIV_FIRST-1].carea - r_st[DIV_FIRST-1].tarea};
        end else begin
            n_st[DIV_FIRST].q   = '0;
            n_st[DIV_FIRST].rem = {1'b0, r_st[DIV_FIRST-1].carea};
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = DIV_FIRST + 1; k < DIV_FIRST + RB; k++) begin : g_div
        logic [vrtt_pkg::REM_BITS-1:0] w_r2, w_d;
        always_comb begin
            w_r2 = {r_st[k-1].rem[vrtt_pkg::REM_BITS-2:0], 1'b0};
            w_d  = {1'b0, r_st[k-1].tarea};
            n_st[k] = r_st[k-1];
            if (w_r2 >= w_d) begin
                n_st[k].rem = w_r2 - w_d;
                n_st[k].q[DIV_FIRST + RB - 1 - k] = 1'b1;
            end else begin
                n_st[k].rem = w_r2;
            end
        end
    end

    // final ratio: zero when hidden or when the target has no area
    always_comb begin
        n_st[LAST] = r_st[LAST-1];
        if (!r_st[LAST-1].vis || (r_st[LAST-1].tarea == '0)) begin
            n_st[LAST].q = '0;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NST; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid && !r_clearing;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // slot to history index, a constant table over every slot value
    logic [SLOT_AW-1:0] w_slot_tab [SLOT_VALS];
    for (genvar v = 0; v < SLOT_VALS; v++) begin : g_slot_tab
        assign w_slot_tab[v] = SLOT_AW'(v % TARGET_SLOTS);
    end

    // slot history memory, read as a beat enters the last stage
    vrtt_pkg::t_hist    r_mem [TARGET_SLOTS];
    vrtt_pkg::t_hist    r_hist;
    logic [SLOT_AW-1:0] r_idx;
    logic [SLOT_AW-1:0] w_rd_idx;
    logic               w_mem_we;
    logic [SLOT_AW-1:0] w_mem_addr;
    vrtt_pkg::t_hist    w_mem_wdata;
    vrtt_pkg::t_hist    w_upd;

    assign w_rd_idx = w_slot_tab[r_st[LAST-1].slot];
    assign w_upd    = '{seen: 1'b1, ratio: r_st[LAST].q};

    always_comb begin
        if (r_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = r_clr_cnt;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_adv && r_vld[LAST];
            w_mem_addr  = r_idx;
            w_mem_wdata = w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_adv) begin
            r_idx <= w_rd_idx;
            // forward the entry written by the beat now leaving
            if (r_vld[LAST] && (r_idx == w_rd_idx)) begin
                r_hist <= w_upd;
            end else begin
                r_hist <= r_mem[w_rd_idx];
            end
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == SLOT_AW'(TARGET_SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // threshold crossing test
    logic [2:0]    w_n_thr;
    logic          w_cross;
    logic          w_report;
    logic [RB-1:0] w_thr;
    always_comb begin
        w_n_thr = (r_thr_count > 3'(MAX_THRESHOLDS)) ? 3'(MAX_THRESHOLDS) : r_thr_count;
        w_cross = 1'b0;
        w_thr   = '0;
        for (int t = 0; t < MAX_THRESHOLDS; t++) begin
            w_thr = r_thresholds[RB*t +: RB];
            if ((3'(t) < w_n_thr) && ((r_hist.ratio >= w_thr) != (r_st[LAST].q >= w_thr))) begin
                w_cross = 1'b1;
            end
        end
        w_report = !r_hist.seen || r_st[LAST].restart || w_cross;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[LAST] && w_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_slot      <= r_st[LAST].slot;
            r_out.visible       <= r_st[LAST].vis;
            r_out.visible_ratio <= r_st[LAST].q;
            r_out.clip_x        <= r_st[LAST].cx;
            r_out.clip_y        <= r_st[LAST].cy;
            r_out.clip_width    <= r_st[LAST].cw;
            r_out.clip_height   <= r_st[LAST].ch;
            r_out.box_x         <= r_st[LAST].tx;
            r_out.box_y         <= r_st[LAST].ty;
            r_out.box_width     <= r_st[LAST].tw;
            r_out.box_height    <= r_st[LAST].th;
        end
    end

endmodule

`default_nettype wire

// ----- sv/vrtt_checker.sv -----
// port-level checks for the visibility ratio tracker, bound to the top level
// depends on vrtt_pkg and the assertion macro header
`default_nettype none
`include "visibility_ratio_threshold_tracker_core_assert.svh"

module vrtt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire vrtt_pkg::t_out_beat o_out_beat
);

    // a stalled result beat holds
    `VRTT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat), "result beat changed while stalled")

    // a hidden target has no ratio and an empty clip
    `VRTT_ASSERT(a_hidden_zero, i_clk, i_rst_n, o_out_valid && !o_out_beat.visible |-> o_out_beat.visible_ratio == '0 && o_out_beat.clip_width == '0 && o_out_beat.clip_height == '0, "hidden target with nonzero clip or ratio")

    // ratio never above full visibility and clip never wider than the box
    `VRTT_ASSERT(a_ratio_range, i_clk, i_rst_n, o_out_valid |-> o_out_beat.visible_ratio <= 16'd32768 && o_out_beat.clip_width <= o_out_beat.box_width, "ratio or clip out of range")

    // no input beat is taken right after reset, while history is cleared
    `VRTT_ASSERT_ALWAYS(a_clear_blocks, i_clk, $rose(i_rst_n) |-> !o_in_ready, "input taken during history clear")

endmodule

bind visibility_ratio_threshold_tracker_core vrtt_checker u_vrtt_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for visibility_ratio_threshold_tracker_core: random and directed target boxes,
// predicted clip, Q1.15 ratio and threshold-crossing reports checked beat by beat
// depends on vrtt_pkg and the core
`default_nettype none

module tb;

    localparam int LATENCY   = 21;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    vrtt_pkg::t_in_beat in_beat;
    vrtt_pkg::t_out_beat out_beat;
    logic cfg_we;
    logic [vrtt_pkg::CFG_IDX_BITS-1:0] cfg_idx;
    logic [vrtt_pkg::CFG_DATA_BITS-1:0] cfg_data;

    visibility_ratio_threshold_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_beat(in_beat),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_beat(out_beat),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor copy of registers and slot history
    logic signed [23:0] m_root_x, m_root_y;
    logic [22:0] m_root_w, m_root_h;
    logic [63:0] m_margins, m_thresh;
    logic m_is_elem;
    logic [2:0] m_thr_count;
    logic [15:0] hist_ratio [64];
    logic hist_seen [64];

    vrtt_pkg::t_in_beat pending_boxes[$];
    vrtt_pkg::t_out_beat expected_reports[$];
    int errors = 0;
    int cycle = 0;
    bit quiet = 0;
    bit hold_sender = 0;
    int send_gap = 0, recv_gap = 0;

    // add a box at the tail of the pending queue
    task automatic queue_box(input vrtt_pkg::t_in_beat b);
        pending_boxes = {pending_boxes, b};
    endtask

    // compute the report a box causes, if any, and update history
    task automatic predict_report(input vrtt_pkg::t_in_beat b);
        longint rx, ry, rw, rh, tx, ty, tw, th, cl, ct, cr, cb, mt, mr, mb, ml;
        longint unsigned tarea, carea, ratio;
        int n;
        bit vis, rep;
        vrtt_pkg::t_out_beat r;
        tx = longint'(b.target_x); ty = longint'(b.target_y);
        tw = longint'(b.target_width); th = longint'(b.target_height);
        if (b.restart) hist_seen[b.slot] = 0;
        if (m_is_elem) begin
            rx = longint'(m_root_x); ry = longint'(m_root_y);
            rw = longint'(m_root_w); rh = longint'(m_root_h);
        end else begin
            mt = longint'($signed(m_margins[15:0]));
            mr = longint'($signed(m_margins[31:16]));
            mb = longint'($signed(m_margins[47:32]));
            ml = longint'($signed(m_margins[63:48]));
            rx = longint'(m_root_x) - ml; ry = longint'(m_root_y) - mt;
            rw = longint'(m_root_w) + ml + mr; rh = longint'(m_root_h) + mt + mb;
        end
        cl = rx > tx ? rx : tx;
        ct = ry > ty ? ry : ty;
        cr = (rx + rw) < (tx + tw) ? rx + rw : tx + tw;
        cb = (ry + rh) < (ty + th) ? ry + rh : ty + th;
        r = '0;
        ratio = 0;
        vis = (cr > cl) && (cb > ct);
        if (vis) begin
            r.clip_x = cl[23:0]; r.clip_y = ct[23:0];
            r.clip_width = 23'(cr - cl); r.clip_height = 23'(cb - ct);
            tarea = $unsigned(tw * th);
            if (tarea != 0) begin
                carea = $unsigned((cr - cl) * (cb - ct));
                ratio = (carea << 15) / tarea;
                if (ratio > 32768) ratio = 32768;
            end
        end
        rep = !hist_seen[b.slot];
        if (!rep) begin
            n = m_thr_count > 3'd4 ? 4 : int'(m_thr_count);
            for (int i = 0; i < n; i++)
                if ((hist_ratio[b.slot] >= m_thresh[16*i +: 16]) !=
                    (ratio >= m_thresh[16*i +: 16])) rep = 1;
        end
        hist_ratio[b.slot] = ratio[15:0];
        hist_seen[b.slot] = 1;
        if (rep) begin
            r.out_slot = b.slot; r.visible = vis; r.visible_ratio = ratio[15:0];
            r.box_x = b.target_x; r.box_y = b.target_y;
            r.box_width = b.target_width; r.box_height = b.target_height;
            expected_reports = {expected_reports, r};
        end
    endtask

    // sender: feeds boxes from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) predict_report(in_beat);
            if (!(in_valid && !in_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_boxes.size() > 0 && !hold_sender) begin
                    in_beat <= pending_boxes.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= int'($urandom_range(1, 12));
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compare each report with the oldest prediction
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t report with none expected: expected none actual %p",
                             $time, out_beat);
                    errors++;
                end else begin
                    vrtt_pkg::t_out_beat e;
                    e = expected_reports.pop_front();
                    if (e.out_slot != out_beat.out_slot || e.visible != out_beat.visible ||
                        e.visible_ratio != out_beat.visible_ratio ||
                        e.clip_x != out_beat.clip_x || e.clip_y != out_beat.clip_y ||
                        e.clip_width != out_beat.clip_width ||
                        e.clip_height != out_beat.clip_height ||
                        e.box_x != out_beat.box_x || e.box_y != out_beat.box_y ||
                        e.box_width != out_beat.box_width ||
                        e.box_height != out_beat.box_height) begin
                        $display("%0t mismatch: expected %p actual %p", $time, e, out_beat);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 6) == 0)
                    recv_gap <= int'($urandom_range(1, 12));
            end
        end
        if (cycle > MAX_CYCLE) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // register write while idle, mirrored in the predictor
    task automatic write_reg(input vrtt_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            vrtt_pkg::CFG_ROOT_X:          m_root_x = val[23:0];
            vrtt_pkg::CFG_ROOT_Y:          m_root_y = val[23:0];
            vrtt_pkg::CFG_ROOT_WIDTH:      m_root_w = val[22:0];
            vrtt_pkg::CFG_ROOT_HEIGHT:     m_root_h = val[22:0];
            vrtt_pkg::CFG_MARGINS:         m_margins = val;
            vrtt_pkg::CFG_ROOT_IS_ELEMENT: m_is_elem = val[0];
            vrtt_pkg::CFG_THRESHOLDS:      m_thresh = val;
            vrtt_pkg::CFG_THRESHOLD_COUNT: m_thr_count = val[2:0];
            default: ;
        endcase
    endtask

    // wait until every box is in and every report is out, then the tail latency
    task automatic drain();
        wait (pending_boxes.size() == 0 && !in_valid && expected_reports.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic vrtt_pkg::t_in_beat make_box(input logic [5:0] s, input logic rs,
                                                    input logic [23:0] x, input logic [23:0] y,
                                                    input logic [22:0] w, input logic [22:0] h);
        vrtt_pkg::t_in_beat b;
        b.slot = s; b.restart = rs; b.target_x = x; b.target_y = y;
        b.target_width = w; b.target_height = h;
        return b;
    endfunction

    // box near the root, mostly small sizes so ratios sweep across thresholds
    function automatic vrtt_pkg::t_in_beat rand_box(input int mode);
        vrtt_pkg::t_in_beat b;
        b = '0;
        b.restart = ($urandom_range(0, 15) == 0);
        b.slot = 6'($urandom_range(0, 7));
        if (mode == 1) b.slot = 6'($urandom);
        if (mode == 0) begin
            b.target_x = $signed(24'($urandom_range(0, 3000))) - 24'sd1000;
            b.target_y = $signed(24'($urandom_range(0, 3000))) - 24'sd1000;
            b.target_width = 23'($urandom_range(0, 1500));
            b.target_height = 23'($urandom_range(0, 1500));
        end else begin
            b.target_x = 24'($urandom); b.target_y = 24'($urandom);
            b.target_width = 23'($urandom); b.target_height = 23'($urandom);
        end
        return b;
    endfunction

    // signed value in [-200, 200] as a 64-bit register word
    function automatic logic [63:0] rand_offset();
        return 64'($signed($urandom_range(0, 400)) - 200);
    endfunction

    task automatic random_phase(input int count);
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            queue_box(rand_box(mode < 7 ? 0 : (mode < 9 ? 1 : 2)));
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0; in_beat = '0; out_ready = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        m_root_x = 0; m_root_y = 0; m_root_w = 0; m_root_h = 0;
        m_margins = 0; m_is_elem = 0; m_thresh = 0; m_thr_count = 1;
        for (int i = 0; i < 64; i++) begin
            hist_seen[i] = 0; hist_ratio[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // viewport with mixed margins and four thresholds
        write_reg(vrtt_pkg::CFG_ROOT_X, 64'd0);
        write_reg(vrtt_pkg::CFG_ROOT_Y, 64'd0);
        write_reg(vrtt_pkg::CFG_ROOT_WIDTH, 64'd1000);
        write_reg(vrtt_pkg::CFG_ROOT_HEIGHT, 64'd800);
        write_reg(vrtt_pkg::CFG_MARGINS, {16'sd50, 16'hFFCE, 16'sd0, 16'sd20});
        write_reg(vrtt_pkg::CFG_ROOT_IS_ELEMENT, 64'd0);
        write_reg(vrtt_pkg::CFG_THRESHOLDS, {16'd32768, 16'd16384, 16'd1, 16'd0});
        write_reg(vrtt_pkg::CFG_THRESHOLD_COUNT, 64'd4);

        // directed: first sightings, full view, partial, off screen, zero area, extremes
        queue_box(make_box(6'd0, 1'b0, 24'd10, 24'd10, 23'd100, 23'd100));
        queue_box(make_box(6'd0, 1'b0, -24'sd100, 24'd10, 23'd200, 23'd100));
        queue_box(make_box(6'd0, 1'b0, 24'd5000, 24'd10, 23'd100, 23'd100));
        queue_box(make_box(6'd0, 1'b0, 24'd10, 24'd10, 23'd100, 23'd100));
        queue_box(make_box(6'd0, 1'b1, 24'd10, 24'd10, 23'd100, 23'd100));
        queue_box(make_box(6'd1, 1'b0, 24'd10, 24'd10, 23'd0, 23'd100));
        queue_box(make_box(6'd1, 1'b0, 24'd10, 24'd10, 23'd100, 23'd0));
        queue_box(make_box(6'd63, 1'b0, 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF));
        queue_box(make_box(6'd63, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF));
        queue_box(make_box(6'd62, 1'b0, 24'd1000, 24'd0, 23'd10, 23'd10));
        queue_box(make_box(6'd62, 1'b0, 24'd999, 24'd799, 23'd10, 23'd10));
        queue_box(make_box(6'd62, 1'b1, -24'sd20, -24'sd50, 23'd1, 23'd1));
        drain();

        // element root at extremes, count above max, then shrunken viewport
        write_reg(vrtt_pkg::CFG_ROOT_IS_ELEMENT, 64'd1);
        write_reg(vrtt_pkg::CFG_ROOT_X, 64'hFFFFFFFFFF800000);
        write_reg(vrtt_pkg::CFG_ROOT_WIDTH, 64'h7FFFFF);
        write_reg(vrtt_pkg::CFG_THRESHOLD_COUNT, 64'd7);
        queue_box(make_box(6'd5, 1'b0, 24'h800000, 24'd0, 23'h7FFFFF, 23'd50));
        queue_box(make_box(6'd5, 1'b0, 24'd0, 24'd0, 23'd0, 23'd0));
        queue_box(make_box(6'd6, 1'b0, 24'd0, 24'd0, 23'd10, 23'd10));
        drain();
        write_reg(vrtt_pkg::CFG_ROOT_IS_ELEMENT, 64'd0);
        write_reg(vrtt_pkg::CFG_MARGINS, {4{16'h8000}});
        queue_box(make_box(6'd7, 1'b0, 24'd0, 24'd0, 23'd10, 23'd10));
        queue_box(make_box(6'd7, 1'b0, 24'd1, 24'd1, 23'd10, 23'd10));
        drain();

        // random phases over several settings
        for (int p = 0; p < 6; p++) begin
            write_reg(vrtt_pkg::CFG_ROOT_X, rand_offset());
            write_reg(vrtt_pkg::CFG_ROOT_Y, rand_offset());
            write_reg(vrtt_pkg::CFG_ROOT_WIDTH,
                      p == 5 ? 64'h7FFFFF : 64'($urandom_range(0, 1500)));
            write_reg(vrtt_pkg::CFG_ROOT_HEIGHT,
                      p == 5 ? 64'h7FFFFF : 64'($urandom_range(0, 1500)));
            write_reg(vrtt_pkg::CFG_MARGINS, p == 4 ? {4{16'h7FFF}} :
                      {16'(rand_offset()), 16'(rand_offset()),
                       16'(rand_offset()), 16'(rand_offset())});
            write_reg(vrtt_pkg::CFG_ROOT_IS_ELEMENT, 64'(p % 2));
            write_reg(vrtt_pkg::CFG_THRESHOLDS, p == 3 ? 64'hFFFF_FFFF_0000_0000 :
                      {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                       16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768))});
            write_reg(vrtt_pkg::CFG_THRESHOLD_COUNT,
                      p == 2 ? 64'd0 : 64'($urandom_range(1, 7)));
            if (p == 5) quiet = 1;
            if (p == 1) begin
                // sender holds back until every report is in
                queue_box(rand_box(0));
                wait (pending_boxes.size() == 0 && !in_valid);
                hold_sender = 1;
                wait (expected_reports.size() == 0);
                hold_sender = 0;
            end
            random_phase(p == 5 ? 150 : 140);
        end

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
